// ===== src/lc3_pkg.sv =====
// Shared types and codes for the LC-3 instruction execute block.
`default_nettype none

package lc3_pkg;

  // Default memory depth in words (power of two).
  localparam int LC3_MEM_WORDS = 65536;

  // Transaction operation codes.
  localparam logic [1:0] OP_EXEC  = 2'd0;
  localparam logic [1:0] OP_MWR   = 2'd1;
  localparam logic [1:0] OP_MRD   = 2'd2;
  localparam logic [1:0] OP_SETPC = 2'd3;

  // LC-3 opcodes, instr[15:12].
  localparam logic [3:0] OPC_BR   = 4'd0;
  localparam logic [3:0] OPC_ADD  = 4'd1;
  localparam logic [3:0] OPC_LD   = 4'd2;
  localparam logic [3:0] OPC_ST   = 4'd3;
  localparam logic [3:0] OPC_JSR  = 4'd4;
  localparam logic [3:0] OPC_AND  = 4'd5;
  localparam logic [3:0] OPC_LDR  = 4'd6;
  localparam logic [3:0] OPC_STR  = 4'd7;
  localparam logic [3:0] OPC_RTI  = 4'd8;
  localparam logic [3:0] OPC_NOT  = 4'd9;
  localparam logic [3:0] OPC_LDI  = 4'd10;
  localparam logic [3:0] OPC_STI  = 4'd11;
  localparam logic [3:0] OPC_JMP  = 4'd12;
  localparam logic [3:0] OPC_RES  = 4'd13;
  localparam logic [3:0] OPC_LEA  = 4'd14;
  localparam logic [3:0] OPC_TRAP = 4'd15;

  // Condition codes.
  localparam logic [2:0] CC_N = 3'd4;
  localparam logic [2:0] CC_Z = 3'd2;
  localparam logic [2:0] CC_P = 3'd1;

  // Register used as link register.
  localparam logic [2:0] REG_LINK = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MEM1,
    S_MEM2
  } state_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] c;
    if (v[15]) c = CC_N;
    else if (v == 16'd0) c = CC_Z;
    else c = CC_P;
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/lc3_instruction_execute.sv =====
// Top level: LC-3 instruction execute sequencer around register file and word memory.
// Results are registered when the transaction finishes: in S_EXEC for ALU, branch, jump,
//   trap, store, write and set-pc transactions; in S_MEM1 for LD, LDR, STI and memory
//   reads; in S_MEM2 for LDI. Each dependent memory read adds a step (main memory read
//   data is registered); the next is taken as one finishes, if the output register is free.
// Reset (rst, synchronous): PC 0, condition code Z, registers read as zero through
//   per-register valid bits; main memory is not cleared and is undefined until written.
`default_nettype none

module lc3_instruction_execute
  import lc3_pkg::*;
#(
  parameter int MEM_WORDS = LC3_MEM_WORDS   // power of two, 256..65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] instr,
  input  wire logic [15:0] addr,
  input  wire logic [15:0] data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      pc_now,
  output logic [2:0]       cond_code,
  output logic [15:0]      read_word,
  output logic             trap_taken,
  output logic [7:0]       trap_vector,
  output logic             illegal
);

  localparam int AW = $clog2(MEM_WORDS);

  // Architectural state
  logic [15:0] rf [8];            // register file, no reset
  logic [7:0]  rf_valid;          // entry written since reset
  logic [15:0] mem [MEM_WORDS];   // main memory
  logic [15:0] pc, pc_next;
  logic [2:0]  cc, cc_next;

  // Captured transaction and its register operands
  logic [1:0]  op_q;
  logic [15:0] instr_q, addr_q, data_q;
  logic [15:0] rf_a, rf_b;        // sr1 and (sr2 or store source)
  logic [15:0] mem_q;             // registered memory read data

  state_t      st, st_next;

  // Datapath controls
  logic        accept, fin, out_free, commit;
  logic        rf_we, set_cc, mem_we, mem_re, trap, bad;
  logic [2:0]  rf_wa;
  logic [15:0] rf_wd, mem_a, mem_wd;

  // Decoded fields of the captured instruction
  logic [3:0]  opc;
  logic [2:0]  dr;
  logic [15:0] off9, off6, off11, imm5, src_b, pc_inc, pc_rel9;

  // Operand read addresses for the incoming transaction
  logic [3:0]  in_opc;
  logic [2:0]  ra, rb;

  assign opc     = instr_q[15:12];
  assign dr      = instr_q[11:9];
  assign off9    = {{7{instr_q[8]}}, instr_q[8:0]};
  assign off6    = {{10{instr_q[5]}}, instr_q[5:0]};
  assign off11   = {{5{instr_q[10]}}, instr_q[10:0]};
  assign imm5    = {{11{instr_q[4]}}, instr_q[4:0]};
  assign src_b   = instr_q[5] ? imm5 : rf_b;
  assign pc_inc  = pc + 16'd1;
  assign pc_rel9 = pc_inc + off9;

  assign in_opc  = instr[15:12];
  assign ra      = instr[8:6];
  // Stores read their source register through the second port.
  assign rb      = (in_opc == OPC_ST || in_opc == OPC_STR || in_opc == OPC_STI)
                   ? instr[11:9] : instr[2:0];

  // A transaction is taken when idle, or in the cycle the current one finishes
  // and its result can move into the output register.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (st == S_IDLE) || (fin && out_free);
  assign accept   = in_valid && in_ready;
  // A finishing step stalled by a full output register has no side effects.
  assign commit   = !fin || out_free;

  always_ff @(posedge clk) begin
    if (rst) st <= S_IDLE;
    else st <= st_next;
  end

  // Sequencer: next state, side effects and result
  always_comb begin
    st_next = st;
    pc_next = pc;
    rf_we   = 1'b0;
    rf_wa   = dr;
    rf_wd   = mem_q;
    set_cc  = 1'b0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_a   = addr_q;
    mem_wd  = rf_b;
    fin     = 1'b0;
    trap    = 1'b0;
    bad     = 1'b0;
    unique case (st)
      S_IDLE: begin
      end
      S_EXEC: begin
        unique case (op_q)
          OP_MWR: begin
            mem_we = 1'b1;
            mem_wd = data_q;
            fin    = 1'b1;
          end
          OP_MRD: begin
            mem_re  = 1'b1;
            st_next = S_MEM1;
          end
          OP_SETPC: begin
            pc_next = addr_q;
            fin     = 1'b1;
          end
          OP_EXEC: begin
            pc_next = pc_inc;
            fin     = 1'b1;
            unique case (opc)
              OPC_BR: begin
                if ((dr & cc) != 3'd0) pc_next = pc_rel9;
              end
              OPC_ADD: begin
                rf_we  = 1'b1;
                set_cc = 1'b1;
                rf_wd  = rf_a + src_b;
              end
              OPC_AND: begin
                rf_we  = 1'b1;
                set_cc = 1'b1;
                rf_wd  = rf_a & src_b;
              end
              OPC_NOT: begin
                rf_we  = 1'b1;
                set_cc = 1'b1;
                rf_wd  = ~rf_a;
              end
              OPC_LEA: begin
                rf_we  = 1'b1;
                set_cc = 1'b1;
                rf_wd  = pc_rel9;
              end
              OPC_LD, OPC_LDI, OPC_STI: begin
                mem_re  = 1'b1;
                mem_a   = pc_rel9;
                fin     = 1'b0;
                st_next = S_MEM1;
              end
              OPC_LDR: begin
                mem_re  = 1'b1;
                mem_a   = rf_a + off6;
                fin     = 1'b0;
                st_next = S_MEM1;
              end
              OPC_ST: begin
                mem_we = 1'b1;
                mem_a  = pc_rel9;
              end
              OPC_STR: begin
                mem_we = 1'b1;
                mem_a  = rf_a + off6;
              end
              OPC_JSR: begin
                // target taken from the operand read before R7 is written
                pc_next = instr_q[11] ? (pc_inc + off11) : rf_a;
                rf_we   = 1'b1;
                rf_wa   = REG_LINK;
                rf_wd   = pc_inc;
              end
              OPC_JMP: begin
                pc_next = rf_a;
              end
              OPC_TRAP: begin
                rf_we = 1'b1;
                rf_wa = REG_LINK;
                rf_wd = pc_inc;
                trap  = 1'b1;
              end
              OPC_RTI, OPC_RES: begin
                pc_next = pc;
                bad     = 1'b1;
              end
            endcase
          end
        endcase
      end
      S_MEM1: begin
        if (op_q == OP_MRD) begin
          fin = 1'b1;
        end else if (opc == OPC_LDI) begin
          mem_re  = 1'b1;
          mem_a   = mem_q;
          st_next = S_MEM2;
        end else if (opc == OPC_STI) begin
          mem_we = 1'b1;
          mem_a  = mem_q;
          fin    = 1'b1;
        end else begin
          rf_we  = 1'b1;
          set_cc = 1'b1;
          fin    = 1'b1;
        end
      end
      S_MEM2: begin
        rf_we  = 1'b1;
        set_cc = 1'b1;
        fin    = 1'b1;
      end
    endcase

    cc_next = set_cc ? cc_of(rf_wd) : cc;

    if (fin) begin
      if (out_free) begin
        st_next = accept ? S_EXEC : S_IDLE;
      end else begin
        // hold: no state change until the output register frees
        pc_next = pc;
        cc_next = cc;
        rf_we   = 1'b0;
        mem_we  = 1'b0;
      end
    end else if (st == S_IDLE && accept) begin
      st_next = S_EXEC;
    end
  end

  // PC and condition code
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 16'd0;
      cc <= CC_Z;
    end else begin
      pc <= pc_next;
      cc <= cc_next;
    end
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      instr_q <= instr;
      addr_q  <= addr;
      data_q  <= data;
    end
  end

  // Register file: synchronous read at accept, forwarding the write of the same edge
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (accept) begin
      if (rf_we && rf_wa == ra) rf_a <= rf_wd;
      else rf_a <= rf_valid[ra] ? rf[ra] : 16'd0;
      if (rf_we && rf_wa == rb) rf_b <= rf_wd;
      else rf_b <= rf_valid[rb] ? rf[rb] : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) rf_valid <= 8'd0;
    else if (rf_we) rf_valid[rf_wa] <= 1'b1;
  end

  // Main memory: one access per cycle, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a[AW-1:0]] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_a[AW-1:0]];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (fin && commit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fin && commit) begin
      pc_now      <= pc_next;
      cond_code   <= cc_next;
      read_word   <= (op_q == OP_MRD) ? mem_q : 16'd0;
      trap_taken  <= trap;
      trap_vector <= trap ? instr_q[7:0] : 8'd0;
      illegal     <= bad;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("memory read and write in the same cycle");

  a_rf_write_at_finish: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> fin && commit)
    else $error("register write outside a committed finish");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> st == S_EXEC)
    else $error("accepted transaction not in execute");

  a_cc_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(cond_code))
    else $error("condition code not one-hot");

  a_trap_not_illegal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trap_taken && illegal))
    else $error("trap and illegal together");
`endif

endmodule

`default_nettype wire
